// ===== src/assert_macros.svh =====
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== src/spp_pkg.sv =====
`timescale 1ns / 1ps

package spp_pkg;

    localparam int PAN_W      = 16;
    localparam int PAN_FRAC_W = 16;
    localparam int ACC_W      = 32;
    localparam int STEPS_W    = 12;
    localparam int GAIN_W     = 17;
    localparam int MUL_B_W    = 18;
    localparam int DIV_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int FRAC_SHIFT = 15;
    localparam int ROUND_BIAS = 16384;

    localparam logic [GAIN_W-1:0] FULL_SCALE  = 17'h10000;
    localparam logic [63:0]       HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0]       ONE_Q30     = 64'd1073741824;

    localparam logic [CFG_IDX_W-1:0] CFG_PAN_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAN_LAW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEPS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MONO_INPUT = 2'd3;

    localparam logic LAW_LINEAR = 1'b0;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_GOAL   = 13'b0000000000010,
        S_DIV    = 13'b0000000000100,
        S_STEP   = 13'b0000000001000,
        S_GAIN   = 13'b0000000010000,
        S_SCALE  = 13'b0000000100000,
        S_ADDR   = 13'b0000001000000,
        S_BASE   = 13'b0000010000000,
        S_NEXT   = 13'b0000100000000,
        S_INTERP = 13'b0001000000000,
        S_MUL_L  = 13'b0010000000000,
        S_MUL_R  = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } state_t;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [STEPS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    // quarter-wave sine of a Q30 angle, Q1.15 result, series in nested form
    function automatic logic [15:0] sine_q15(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] s;
        x2   = (x * x) >> 30;
        term = ONE_Q30;
        term = ONE_Q30 - ((x2 * term) >> 30) / 110;
        term = ONE_Q30 - ((x2 * term) >> 30) / 72;
        term = ONE_Q30 - ((x2 * term) >> 30) / 42;
        term = ONE_Q30 - ((x2 * term) >> 30) / 20;
        term = ONE_Q30 - ((x2 * term) >> 30) / 6;
        s = (x * term) >> 30;
        s = (s + 64'd16384) >> 15;
        if (s > 64'd32768)
        begin
            s = 64'd32768;
        end
        return s[15:0];
    endfunction

endpackage

// ===== src/spp_divider.sv =====
`timescale 1ns / 1ps

module spp_divider
    import spp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [STEPS_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0]   quo_reg, quo_next;
    logic [STEPS_W-1:0] divisor_reg, divisor_next;

    logic [STEPS_W:0] shifted;
    logic [STEPS_W:0] trial;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign fits    = shifted >= {1'b0, divisor_reg};
    assign trial   = shifted - {1'b0, divisor_reg};

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (req.start)
        begin
            busy_next    = 1'b1;
            count_next   = '0;
            rem_next     = '0;
            quo_next     = req.dividend;
            divisor_next = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? trial[STEPS_W-1:0] : shifted[STEPS_W-1:0];
            quo_next   = {quo_reg[DIV_W-2:0], fits};
            count_next = count_reg + 1'b1;
            if (count_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== src/spp_mult.sv =====
`timescale 1ns / 1ps

module spp_mult
    import spp_pkg::*;
#(
    parameter int A_WIDTH = 25
)
(
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [A_WIDTH-1:0]           a,
    input  logic signed [MUL_B_W-1:0]           b,
    output logic signed [A_WIDTH+MUL_B_W-1:0]   prod
);

    logic signed [A_WIDTH+MUL_B_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== src/spp_sine_rom.sv =====
`timescale 1ns / 1ps

module spp_sine_rom
    import spp_pkg::*;
#(
    parameter int DEPTH = 256
)
(
    input  logic                           clk,
    input  logic                           en,
    input  logic [$clog2(DEPTH+1)-1:0]     addr,
    output logic [15:0]                    data
);

    logic [15:0] rom_entry [DEPTH+1];
    logic [15:0] data_reg;

    for (genvar gi = 0; gi <= DEPTH; gi++)
    begin : g_entry
        localparam logic [63:0] ANGLE = (HALF_PI_Q30 * 64'(gi)) / 64'(DEPTH);
        localparam logic [15:0] VALUE = sine_q15(ANGLE);
        assign rom_entry[gi] = VALUE;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= rom_entry[addr];
        end
    end

    assign data = data_reg;

endmodule

// ===== src/smoothed_stereo_panner.sv =====
// each transaction runs the states from S_GOAL to S_DONE; the linear law skips S_SCALE to S_INTERP
// a new pan target over a ramp of two or more steps also waits in S_DIV for the divider
// one transaction at a time: a new sample is taken only in S_IDLE
// a result still waiting for out_ready holds the next transaction in its last state
// constant power gains come from one shared multiplier and one table read port, used in turn
// reset: asynchronous active low; pan centered, constant power law, 960-sample ramp
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smoothed_stereo_panner
    import spp_pkg::*;
#(
    parameter int SAMPLE_WIDTH     = 24,
    parameter int SINE_TABLE_DEPTH = 256
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] left_in,
    input  logic signed [SAMPLE_WIDTH-1:0] right_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] left_out,
    output logic signed [SAMPLE_WIDTH-1:0] right_out
);

    localparam int A_WIDTH = ((SAMPLE_WIDTH > GAIN_W) ? SAMPLE_WIDTH : GAIN_W) + 1;
    localparam int P_WIDTH = A_WIDTH + MUL_B_W;
    localparam int AW      = $clog2(SINE_TABLE_DEPTH + 1);
    localparam logic [AW-1:0] IDX_LAST = AW'(SINE_TABLE_DEPTH);

    state_t state_reg, state_next;

    logic signed [PAN_W-1:0] pan_target_reg, pan_target_next;
    logic                    pan_law_reg, pan_law_next;
    logic [STEPS_W-1:0]      ramp_steps_reg, ramp_steps_next;
    logic                    mono_reg, mono_next;

    logic signed [ACC_W-1:0] current_pan_reg, current_pan_next;
    logic signed [ACC_W-1:0] inc_reg, inc_next;
    logic [STEPS_W-1:0]      steps_rem_reg, steps_rem_next;
    logic signed [PAN_W-1:0] goal_reg, goal_next;
    logic                    side_reg, side_next;
    logic                    out_valid_reg, out_valid_next;

    logic signed [SAMPLE_WIDTH-1:0] l_src_reg, l_src_next;
    logic signed [SAMPLE_WIDTH-1:0] r_src_reg, r_src_next;
    logic [GAIN_W-1:0]              gain_l_reg, gain_l_next;
    logic [GAIN_W-1:0]              gain_r_reg, gain_r_next;
    logic [AW-1:0]                  idx_reg, idx_next;
    logic [PAN_FRAC_W-1:0]          frac_reg, frac_next;
    logic [15:0]                    base_reg, base_next;
    logic                           inc_neg_reg, inc_neg_next;
    logic signed [SAMPLE_WIDTH-1:0] left_res_reg, left_res_next;
    logic signed [SAMPLE_WIDTH-1:0] left_out_reg, left_out_next;
    logic signed [SAMPLE_WIDTH-1:0] right_out_reg, right_out_next;

    logic                       mul_en;
    logic signed [A_WIDTH-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [P_WIDTH-1:0]  mul_prod;
    logic signed [P_WIDTH-1:0]  rounded;

    logic           rom_en;
    logic [AW-1:0]  rom_addr;
    logic [15:0]    rom_data;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [PAN_W-1:0]        pos;
    logic [GAIN_W-1:0]       q_r;
    logic [GAIN_W-1:0]       q_l;
    logic signed [ACC_W:0]   pan_diff;
    logic [ACC_W:0]          pan_mag;
    logic signed [ACC_W-1:0] goal_full;
    logic signed [ACC_W-1:0] target_full;

    spp_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    spp_mult #(
        .A_WIDTH (A_WIDTH)
    ) u_mult (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    spp_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_sine_rom (
        .clk  (clk),
        .en   (rom_en),
        .addr (rom_addr),
        .data (rom_data)
    );

    assign pos         = {~current_pan_reg[ACC_W-1], current_pan_reg[ACC_W-2:PAN_FRAC_W]};
    assign q_r         = {1'b0, pos};
    assign q_l         = FULL_SCALE - q_r;
    assign goal_full   = {goal_reg, {PAN_FRAC_W{1'b0}}};
    assign target_full = {pan_target_reg, {PAN_FRAC_W{1'b0}}};
    assign pan_diff    = {target_full[ACC_W-1], target_full}
                       - {current_pan_reg[ACC_W-1], current_pan_reg};
    assign pan_mag     = pan_diff[ACC_W] ? (~pan_diff + 1'b1) : pan_diff;
    assign rounded     = mul_prod + P_WIDTH'(ROUND_BIAS);

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        pan_target_next  = pan_target_reg;
        pan_law_next     = pan_law_reg;
        ramp_steps_next  = ramp_steps_reg;
        mono_next        = mono_reg;
        current_pan_next = current_pan_reg;
        inc_next         = inc_reg;
        steps_rem_next   = steps_rem_reg;
        goal_next        = goal_reg;
        side_next        = side_reg;
        out_valid_next   = out_valid_reg;
        l_src_next       = l_src_reg;
        r_src_next       = r_src_reg;
        gain_l_next      = gain_l_reg;
        gain_r_next      = gain_r_reg;
        idx_next         = idx_reg;
        frac_next        = frac_reg;
        base_next        = base_reg;
        inc_neg_next     = inc_neg_reg;
        left_res_next    = left_res_reg;
        left_out_next    = left_out_reg;
        right_out_next   = right_out_reg;
        mul_en           = 1'b0;
        mul_a            = '0;
        mul_b            = '0;
        rom_en           = 1'b0;
        rom_addr         = '0;
        div_req          = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    l_src_next = left_in;
                    r_src_next = mono_reg ? left_in : right_in;
                    state_next = S_GOAL;
                end
            end
            S_GOAL:
            begin
                state_next = S_STEP;
                if (pan_target_reg != goal_reg)
                begin
                    goal_next = pan_target_reg;
                    if (ramp_steps_reg == '0)
                    begin
                        current_pan_next = target_full;
                        inc_next         = '0;
                        steps_rem_next   = '0;
                    end
                    else
                    begin
                        steps_rem_next = ramp_steps_reg;
                        inc_next       = '0;
                        if (ramp_steps_reg > STEPS_W'(1))
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = pan_mag[DIV_W-1:0];
                            div_req.divisor  = ramp_steps_reg;
                            inc_neg_next     = pan_diff[ACC_W];
                            state_next       = S_DIV;
                        end
                    end
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    inc_next   = inc_neg_reg ? -$signed(div_rsp.quotient)
                                             : $signed(div_rsp.quotient);
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (steps_rem_reg != '0)
                begin
                    steps_rem_next = steps_rem_reg - 1'b1;
                    if (steps_rem_reg == STEPS_W'(1))
                    begin
                        current_pan_next = goal_full;
                    end
                    else
                    begin
                        current_pan_next = current_pan_reg + inc_reg;
                    end
                end
                state_next = S_GAIN;
            end
            S_GAIN:
            begin
                if (pan_law_reg == LAW_LINEAR)
                begin
                    gain_l_next = q_l >> 1;
                    gain_r_next = q_r >> 1;
                    state_next  = S_MUL_L;
                end
                else
                begin
                    side_next  = 1'b0;
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                mul_en     = 1'b1;
                mul_a      = A_WIDTH'(side_reg ? q_l : q_r);
                mul_b      = MUL_B_W'(SINE_TABLE_DEPTH);
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                idx_next   = mul_prod[PAN_FRAC_W +: AW];
                frac_next  = mul_prod[PAN_FRAC_W-1:0];
                rom_en     = 1'b1;
                rom_addr   = mul_prod[PAN_FRAC_W +: AW];
                state_next = S_BASE;
            end
            S_BASE:
            begin
                base_next  = rom_data;
                rom_en     = 1'b1;
                rom_addr   = (idx_reg == IDX_LAST) ? idx_reg : idx_reg + 1'b1;
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                mul_en     = 1'b1;
                mul_a      = A_WIDTH'(rom_data - base_reg);
                mul_b      = MUL_B_W'(frac_reg);
                state_next = S_INTERP;
            end
            S_INTERP:
            begin
                if (side_reg)
                begin
                    gain_l_next = GAIN_W'(base_reg) + GAIN_W'(mul_prod[2*PAN_FRAC_W-1:PAN_FRAC_W]);
                    state_next  = S_MUL_L;
                end
                else
                begin
                    gain_r_next = GAIN_W'(base_reg) + GAIN_W'(mul_prod[2*PAN_FRAC_W-1:PAN_FRAC_W]);
                    side_next   = 1'b1;
                    state_next  = S_SCALE;
                end
            end
            S_MUL_L:
            begin
                mul_en     = 1'b1;
                mul_a      = A_WIDTH'(l_src_reg);
                mul_b      = MUL_B_W'(gain_l_reg);
                state_next = S_MUL_R;
            end
            S_MUL_R:
            begin
                left_res_next = rounded[FRAC_SHIFT +: SAMPLE_WIDTH];
                mul_en        = 1'b1;
                mul_a         = A_WIDTH'(r_src_reg);
                mul_b         = MUL_B_W'(gain_r_reg);
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    left_out_next  = left_res_reg;
                    right_out_next = rounded[FRAC_SHIFT +: SAMPLE_WIDTH];
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // register writes, only while idle
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PAN_TARGET:
                begin
                    pan_target_next = cfg_data[PAN_W-1:0];
                end
                CFG_PAN_LAW:
                begin
                    pan_law_next = cfg_data[0];
                end
                CFG_RAMP_STEPS:
                begin
                    ramp_steps_next  = cfg_data[STEPS_W-1:0];
                    current_pan_next = goal_full;
                    inc_next         = '0;
                    steps_rem_next   = '0;
                end
                CFG_MONO_INPUT:
                begin
                    mono_next = cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            pan_target_reg  <= '0;
            pan_law_reg     <= 1'b1;
            ramp_steps_reg  <= STEPS_W'(960);
            mono_reg        <= 1'b0;
            current_pan_reg <= '0;
            inc_reg         <= '0;
            steps_rem_reg   <= '0;
            goal_reg        <= '0;
            side_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pan_target_reg  <= pan_target_next;
            pan_law_reg     <= pan_law_next;
            ramp_steps_reg  <= ramp_steps_next;
            mono_reg        <= mono_next;
            current_pan_reg <= current_pan_next;
            inc_reg         <= inc_next;
            steps_rem_reg   <= steps_rem_next;
            goal_reg        <= goal_next;
            side_reg        <= side_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l_src_reg     <= l_src_next;
        r_src_reg     <= r_src_next;
        gain_l_reg    <= gain_l_next;
        gain_r_reg    <= gain_r_next;
        idx_reg       <= idx_next;
        frac_reg      <= frac_next;
        base_reg      <= base_next;
        inc_neg_reg   <= inc_neg_next;
        left_res_reg  <= left_res_next;
        left_out_reg  <= left_out_next;
        right_out_reg <= right_out_next;
    end

    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

    `ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `ASSERT_IMP(a_rem_within_steps, 1'b1, steps_rem_reg <= ramp_steps_reg)
    `ASSERT_NXT(a_last_step_lands, (state_reg == S_STEP) && (steps_rem_reg == STEPS_W'(1)), current_pan_reg == goal_full)
    `ASSERT_IMP(a_div_done_in_wait, div_rsp.done, state_reg == S_DIV)

endmodule

// ===== test/tb_smoothed_stereo_panner.sv =====
`timescale 1ns / 1ps

module tb_smoothed_stereo_panner;
    import spp_pkg::*;

    localparam int SW          = 24;
    localparam int SINE_DEPTH  = 256;
    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1900;
    localparam logic [63:0] ANGLE_QUARTER = 64'd1686629713;
    localparam logic [63:0] UNITY_Q30     = 64'd1073741824;

    typedef struct packed {
        logic signed [SW-1:0] left;
        logic signed [SW-1:0] right;
    } pan_pair_t;

    class pan_scoreboard;
        bit [16:0] sine_tab [0:SINE_DEPTH];
        longint target;
        longint goal;
        longint cur;
        longint incr;
        int unsigned steps_cfg;
        int unsigned steps_left;
        bit law;
        bit mono;
        int errors;
        pan_pair_t expected_pairs[$];

        function new();
            bit [63:0] ang;
            bit [63:0] ang2;
            bit [63:0] term;
            bit [63:0] s;
            bit [63:0] divs [0:4];
            divs = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
            for (int i = 0; i <= SINE_DEPTH; i++)
            begin
                ang = ANGLE_QUARTER * i / SINE_DEPTH;
                ang2 = (ang * ang) >> 30;
                term = UNITY_Q30;
                for (int k = 0; k < 5; k++)
                begin
                    term = UNITY_Q30 - ((ang2 * term) >> 30) / divs[k];
                end
                s = (ang * term) >> 30;
                s = (s + 64'd16384) >> 15;
                if (s > 64'd32768)
                begin
                    s = 64'd32768;
                end
                sine_tab[i] = s[16:0];
            end
            target = 0;
            goal = 0;
            cur = 0;
            incr = 0;
            steps_cfg = 960;
            steps_left = 0;
            law = 1'b1;
            mono = 1'b0;
            errors = 0;
        endfunction

        function int unsigned sine_at(int unsigned q);
            int unsigned scaled;
            int unsigned idx;
            bit [63:0] frac;
            bit [63:0] delta;
            scaled = q * SINE_DEPTH;
            idx = scaled >> 16;
            frac = scaled & 32'hFFFF;
            if (idx >= SINE_DEPTH)
            begin
                return sine_tab[SINE_DEPTH];
            end
            delta = sine_tab[idx + 1] - sine_tab[idx];
            return sine_tab[idx] + 32'((delta * frac) >> 16);
        endfunction

        function logic signed [SW-1:0] apply_gain(longint sample, int unsigned gain);
            longint prod;
            prod = sample * longint'(gain) + 16384;
            return SW'(prod >>> 15);
        endfunction

        function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PAN_TARGET: target = longint'(signed'(data));
                CFG_PAN_LAW: law = data[0];
                CFG_RAMP_STEPS:
                begin
                    steps_cfg = data[11:0];
                    cur = goal * 65536;
                    incr = 0;
                    steps_left = 0;
                end
                CFG_MONO_INPUT: mono = data[0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic signed [SW-1:0] l, logic signed [SW-1:0] r);
            longint src_l;
            longint src_r;
            longint offset;
            int unsigned pos;
            int unsigned gl;
            int unsigned gr;
            pan_pair_t pair;
            if (target != goal)
            begin
                goal = target;
                if (steps_cfg == 0)
                begin
                    cur = goal * 65536;
                    incr = 0;
                    steps_left = 0;
                end
                else
                begin
                    steps_left = steps_cfg;
                    incr = (steps_cfg >= 2) ? (goal * 65536 - cur) / longint'(steps_cfg) : 0;
                end
            end
            if (steps_left != 0)
            begin
                steps_left--;
                if (steps_left == 0)
                    cur = goal * 65536;
                else
                    cur += incr;
            end
            offset = cur + 64'sh8000_0000;
            pos = 32'(offset[31:16]);
            if (law == LAW_LINEAR)
            begin
                gl = (65536 - pos) >> 1;
                gr = pos >> 1;
            end
            else
            begin
                gl = sine_at(65536 - pos);
                gr = sine_at(pos);
            end
            src_l = l;
            src_r = mono ? src_l : longint'(r);
            pair.left = apply_gain(src_l, gl);
            pair.right = apply_gain(src_r, gr);
            expected_pairs.push_back(pair);
        endfunction

        function void check_output(logic signed [SW-1:0] l, logic signed [SW-1:0] r);
            pan_pair_t pair;
            if (expected_pairs.size() == 0)
            begin
                $display("%0t: output transaction with nothing expected, actual %0d %0d",
                         $time, l, r);
                errors++;
                return;
            end
            pair = expected_pairs.pop_front();
            if (l !== pair.left)
            begin
                $display("%0t: left_out mismatch, expected %0d actual %0d",
                         $time, pair.left, l);
                errors++;
            end
            if (r !== pair.right)
            begin
                $display("%0t: right_out mismatch, expected %0d actual %0d",
                         $time, pair.right, r);
                errors++;
            end
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [SW-1:0] left_in = '0;
    logic signed [SW-1:0] right_in = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [SW-1:0] left_out;
    logic signed [SW-1:0] right_out;

    pan_scoreboard sb;
    int idle_pct;
    int stall_pct;
    int quiet_cycles;
    int sent;
    int phase;
    int batch;

    smoothed_stereo_panner #(
        .SAMPLE_WIDTH(SW),
        .SINE_TABLE_DEPTH(SINE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .left_in(left_in),
        .right_in(right_in),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .left_out(left_out),
        .right_out(right_out)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
            sb.write_reg(cfg_index, cfg_data);
        if (rst_n && in_valid && in_ready)
            sb.note_sample(left_in, right_in);
        if (rst_n && out_valid && out_ready)
            sb.check_output(left_out, right_out);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic set_mode(int mode);
        case (mode)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 82; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 82; end
            default: begin idle_pct = 17; stall_pct = 17; end
        endcase
    endtask

    // keeps cfg_valid high so back-to-back writes need no drop
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic cfg_done();
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(logic [SW-1:0] l, logic [SW-1:0] r);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        left_in <= l;
        right_in <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [SW-1:0] rand_sample();
        case ($urandom_range(9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return '0;
            3: return SW'(int'($urandom_range(64)) - 32);
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_target();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_steps();
        logic [11:0] n;
        case ($urandom_range(19))
            0: n = 12'd0;
            1: n = 12'd1;
            2: n = 12'd2;
            3: n = 12'd4095;
            4, 5, 6: n = 12'($urandom_range(100, 400));
            default: n = 12'($urandom_range(3, 48));
        endcase
        return {4'($urandom), n};
    endfunction

    task automatic shuffle_config();
        if ($urandom_range(2) != 0)
            write_reg(CFG_PAN_TARGET, rand_target());
        if ($urandom_range(3) == 0)
            write_reg(CFG_PAN_LAW, 16'($urandom));
        if ($urandom_range(2) == 0)
            write_reg(CFG_RAMP_STEPS, rand_steps());
        if ($urandom_range(3) == 0)
            write_reg(CFG_MONO_INPUT, 16'($urandom));
        cfg_done();
    endtask

    initial
    begin
        sb = new();
        sent = 0;
        quiet_cycles = 0;
        set_mode(0);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // centered, constant power, reset settings
        send_sample(24'h7FFFFF, 24'h7FFFFF);
        send_sample(24'h800000, 24'h800000);
        send_sample(24'h000000, 24'h000000);
        send_sample(24'h7FFFFF, 24'h800000);
        send_sample(24'hFFFFFF, 24'h000001);
        settle();

        // immediate jump to full left, then full right
        write_reg(CFG_RAMP_STEPS, 16'h0000);
        write_reg(CFG_PAN_TARGET, 16'h8000);
        cfg_done();
        send_sample(24'h7FFFFF, 24'h7FFFFF);
        send_sample(24'h800000, 24'h800000);
        settle();
        write_reg(CFG_PAN_TARGET, 16'h7FFF);
        cfg_done();
        send_sample(24'h7FFFFF, 24'h800000);
        send_sample(24'h800000, 24'h7FFFFF);
        settle();

        // linear law, upper data bits set
        write_reg(CFG_PAN_LAW, 16'hFFFE);
        write_reg(CFG_PAN_TARGET, 16'h8000);
        cfg_done();
        send_sample(24'h7FFFFF, 24'h7FFFFF);
        send_sample(24'h800000, 24'h800000);
        settle();

        // mono source
        write_reg(CFG_MONO_INPUT, 16'h0001);
        write_reg(CFG_PAN_TARGET, 16'h0000);
        cfg_done();
        send_sample(24'd123457, -24'sd777);
        send_sample(24'h800000, 24'h7FFFFF);
        settle();

        // one-step ramp lands on the goal
        write_reg(CFG_MONO_INPUT, 16'hFFFE);
        write_reg(CFG_RAMP_STEPS, 16'h0001);
        write_reg(CFG_PAN_TARGET, 16'd20000);
        cfg_done();
        send_sample(24'h7FFFFF, 24'h7FFFFF);
        settle();

        // short ramp to full left, constant power again
        write_reg(CFG_PAN_LAW, 16'h0001);
        write_reg(CFG_RAMP_STEPS, 16'h0003);
        write_reg(CFG_PAN_TARGET, 16'h8000);
        cfg_done();
        repeat (4) send_sample(24'h7FFFFF, 24'h7FFFFF);
        settle();

        // ramp kept through a write of the same target, then cut short by a steps write
        write_reg(CFG_RAMP_STEPS, 16'd100);
        write_reg(CFG_PAN_TARGET, 16'd20000);
        cfg_done();
        repeat (3) send_sample(24'h400000, 24'hC00000);
        settle();
        write_reg(CFG_PAN_TARGET, 16'd20000);
        cfg_done();
        repeat (2) send_sample(24'h400000, 24'hC00000);
        settle();
        write_reg(CFG_RAMP_STEPS, 16'hF005);
        cfg_done();
        repeat (2) send_sample(24'h400000, 24'hC00000);
        settle();

        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            set_mode(phase % 4);
            shuffle_config();
            batch = $urandom_range(20, 76);
            repeat (batch) send_sample(rand_sample(), rand_sample());
            settle();
            phase++;
        end

        repeat (60) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/spp_pkg.sv
src/spp_divider.sv
src/spp_mult.sv
src/spp_sine_rom.sv
src/smoothed_stereo_panner.sv
test/tb_smoothed_stereo_panner.sv
